FILE: src/sli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list package
// Operation and status codes, field widths and the cell command struct.
// ----------------------------------------------------------------------------
package sli_pkg;

   localparam int FUNC_W   = 2;
   localparam int ITEM_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 5;
   localparam int CNT_W    = 6;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic ins;
      logic rem;
      logic clr;
   } cmd_type;

endpackage
`default_nettype wire

FILE: src/sli_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list cell
// One slot: holds a value and its occupied flag, compares against the word
// in flight and keeps its own entry, takes a neighbor's or takes the word.
// ----------------------------------------------------------------------------
module sli_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire sli_pkg::cmd_type  cmd,
   input  wire  [VALUE_WIDTH-1:0] item,
   input  wire  [VALUE_WIDTH-1:0] prev_value,
   input  wire                    prev_valid,
   input  wire                    prev_ge,
   input  wire                    prev_seen,
   input  wire  [VALUE_WIDTH-1:0] next_value,
   input  wire                    next_valid,
   output logic [VALUE_WIDTH-1:0] value,
   output logic                   valid,
   output logic                   ge,
   output logic                   seen,
   output logic                   ins_hit,
   output logic                   rem_hit
);
   import sli_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;
   logic                   valid_ff;
   logic                   valid_in;
   logic                   eq;

   // empty slots count as not less than any value
   assign ge      = !valid_ff || ($signed(value_ff) >= $signed(item));
   assign eq      = valid_ff && (value_ff == item);
   assign seen    = prev_seen || eq;
   assign ins_hit = ge && !prev_ge;
   assign rem_hit = eq && !prev_seen;
   assign value   = value_ff;
   assign valid   = valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (cmd.clr) begin
         valid_in = 1'b0;
      end else if (cmd.ins) begin
         if (ge) begin
            value_in = prev_ge ? prev_value : item;
            valid_in = valid_ff || prev_valid;
         end
      end else if (cmd.rem) begin
         if (seen) begin
            value_in = next_value;
            valid_in = next_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/sli_enc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list slot encoder
// Turns a one-hot (or all-zero) slot vector into a slot index.
// ----------------------------------------------------------------------------
module sli_enc #(
   parameter int CAPACITY = 32
) (
   input  wire  [CAPACITY-1:0]                          hit,
   output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] index
);
   import sli_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   always_comb begin
      index = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

endmodule
`default_nettype wire

FILE: src/sorted_list_insert_remove.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted list insert / remove
// Ascending list of signed values, packed toward slot 0, in a row of cells.
//
// req_ carries one word per operation: insert, remove first equal, clear.
// rsp_ returns one word per operation: status, slot, search and shift
// counts, entry count and empty / full flags.
// Every cell compares the incoming value at once and shifts toward its
// neighbor in the same cycle, so the list is updated at the accept edge.
// The slot index is encoded in the next cycle, from the pending stage, and
// the word is registered in the output stage: one word per cycle while
// rsp_ready does not stall. A stalled rsp_ready holds the output word;
// one more word is then taken into the pending stage, after which
// req_ready drops. Reset empties the list (occupied flags cleared, values
// untouched) and drops both pending and output words.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove #(
   parameter int CAPACITY    = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [sli_pkg::FUNC_W-1:0]         req_func,
   input  wire  signed [sli_pkg::ITEM_W-1:0]  req_item_value,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [sli_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sli_pkg::POS_W-1:0]          rsp_position,
   output logic [sli_pkg::CNT_W-1:0]          rsp_comparisons,
   output logic [sli_pkg::CNT_W-1:0]          rsp_moves,
   output logic [sli_pkg::CNT_W-1:0]          rsp_entry_count,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full
);
   import sli_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int NUM_W = $clog2(CAPACITY + 1);

   logic                   accept;
   logic [VALUE_WIDTH-1:0] item;
   logic                   full;
   cmd_type                cmd;

   logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]    cell_valid;
   logic [CAPACITY-1:0]    cell_ge;
   logic [CAPACITY-1:0]    cell_seen;
   logic [CAPACITY-1:0]    cell_ins_hit;
   logic [CAPACITY-1:0]    cell_rem_hit;
   logic                   found;

   logic [NUM_W-1:0]       count_ff;
   logic [NUM_W-1:0]       count_in;

   logic                   pend_ff;
   logic                   pend_in;
   logic [CAPACITY-1:0]    pend_hit_ff;
   logic [CAPACITY-1:0]    pend_hit_in;
   status_type             pend_status_ff;
   status_type             pend_status_in;
   logic                   pend_ins_ff;
   logic                   pend_ins_in;
   logic [NUM_W-1:0]       pend_count_ff;
   logic                   pend_move;

   logic [IDX_W-1:0]       hit_index;
   logic [NUM_W-1:0]       moves_num;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [POS_W-1:0]       rsp_position_ff;
   logic [CNT_W-1:0]       rsp_comparisons_ff;
   logic [CNT_W-1:0]       rsp_moves_ff;
   logic [CNT_W-1:0]       rsp_entry_count_ff;
   logic                   rsp_is_empty_ff;
   logic                   rsp_is_full_ff;

   assign pend_move = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!pend_ff || pend_move);
   assign accept    = req_valid && req_ready;
   assign item      = VALUE_WIDTH'(req_item_value);
   assign full      = (count_ff == NUM_W'(CAPACITY));

   assign cmd.ins = accept && (req_func == FUNC_INSERT) && !full;
   assign cmd.rem = accept && (req_func == FUNC_REMOVE);
   assign cmd.clr = accept && (req_func == FUNC_CLEAR);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_WIDTH-1:0] prev_value;
      logic                   prev_valid;
      logic                   prev_ge;
      logic                   prev_seen;
      logic [VALUE_WIDTH-1:0] next_value;
      logic                   next_valid;

      if (i == 0) begin : g_head
         assign prev_value = item;
         assign prev_valid = 1'b1;
         assign prev_ge    = 1'b0;
         assign prev_seen  = 1'b0;
      end else begin : g_link
         assign prev_value = cell_value[i-1];
         assign prev_valid = cell_valid[i-1];
         assign prev_ge    = cell_ge[i-1];
         assign prev_seen  = cell_seen[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_value = cell_value[i];
         assign next_valid = 1'b0;
      end else begin : g_body
         assign next_value = cell_value[i+1];
         assign next_valid = cell_valid[i+1];
      end

      sli_cell #(
         .VALUE_WIDTH(VALUE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .item       (item),
         .prev_value (prev_value),
         .prev_valid (prev_valid),
         .prev_ge    (prev_ge),
         .prev_seen  (prev_seen),
         .next_value (next_value),
         .next_valid (next_valid),
         .value      (cell_value[i]),
         .valid      (cell_valid[i]),
         .ge         (cell_ge[i]),
         .seen       (cell_seen[i]),
         .ins_hit    (cell_ins_hit[i]),
         .rem_hit    (cell_rem_hit[i])
      );
   end

   assign found = cell_seen[CAPACITY-1];

   always_comb begin
      count_in = count_ff;
      if (cmd.clr) begin
         count_in = '0;
      end else if (cmd.ins) begin
         count_in = count_ff + NUM_W'(1);
      end else if (cmd.rem && found) begin
         count_in = count_ff - NUM_W'(1);
      end
   end

   always_comb begin
      pend_in        = pend_ff && !pend_move;
      pend_hit_in    = '0;
      pend_status_in = STATUS_DONE;
      pend_ins_in    = cmd.ins;
      if (accept) begin
         pend_in = 1'b1;
      end
      if (cmd.ins) begin
         pend_hit_in = cell_ins_hit;
      end else if (cmd.rem) begin
         pend_hit_in = cell_rem_hit;
      end
      case (req_func)
         FUNC_INSERT: begin
            if (full) begin
               pend_status_in = STATUS_FULL;
            end
         end
         FUNC_REMOVE: begin
            if (!found) begin
               pend_status_in = STATUS_NOT_FOUND;
            end
         end
         default: begin
            pend_status_in = STATUS_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_hit_ff    <= pend_hit_in;
         pend_status_ff <= pend_status_in;
         pend_ins_ff    <= pend_ins_in;
         pend_count_ff  <= count_in;
      end
   end

   sli_enc #(
      .CAPACITY(CAPACITY)
   ) u_enc (
      .hit   (pend_hit_ff),
      .index (hit_index)
   );

   assign moves_num    = pend_count_ff - NUM_W'(1) - NUM_W'(hit_index);
   assign rsp_valid_in = pend_move || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_status_ff      <= pend_status_ff;
         rsp_position_ff    <= POS_W'(hit_index);
         rsp_comparisons_ff <= pend_ins_ff ? CNT_W'(hit_index) : '0;
         rsp_moves_ff       <= pend_ins_ff ? CNT_W'(moves_num) : '0;
         rsp_entry_count_ff <= CNT_W'(pend_count_ff);
         rsp_is_empty_ff    <= (pend_count_ff == '0);
         rsp_is_full_ff     <= (pend_count_ff == NUM_W'(CAPACITY));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_comparisons = rsp_comparisons_ff;
   assign rsp_moves       = rsp_moves_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_is_full     = rsp_is_full_ff;

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list insert / remove testbench
// Drives insert, remove, clear and the unused code on req_, predicts every
// rsp_ word from a shadow copy of the list and checks each field in order.
// Directed words hit the value extremes and duplicates, then random phases
// fill, drain and mix the list under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
   import sli_pkg::*;

   localparam int LIST_DEPTH   = 32;
   localparam int RANDOM_WORDS = 1430;
   localparam int BLOCK_WORDS  = 60;
   localparam int CYCLE_LIMIT  = 500000;
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIX   = 2;

   typedef struct packed {
      status_type          status;
      logic [POS_W-1:0]    position;
      logic [CNT_W-1:0]    comparisons;
      logic [CNT_W-1:0]    moves;
      logic [CNT_W-1:0]    entry_count;
      logic                is_empty;
      logic                is_full;
   } rsp_word_type;

   class list_scoreboard;
      logic signed [ITEM_W-1:0] slot_val [LIST_DEPTH];
      int           fill;
      rsp_word_type expected_rsp [$];
      int           errors;
      int           n_insert, n_reject, n_remove, n_miss, n_clear, n_none, n_full;
      int           words_checked;

      function new();
         fill          = 0;
         errors        = 0;
         n_insert      = 0;
         n_reject      = 0;
         n_remove      = 0;
         n_miss        = 0;
         n_clear       = 0;
         n_none        = 0;
         n_full        = 0;
         words_checked = 0;
      endfunction

      // apply one accepted word to the shadow list, queue its response
      function void note_request(input logic [FUNC_W-1:0] f,
                                 input logic signed [ITEM_W-1:0] v);
         rsp_word_type w;
         int           idx;
         int           i;
         w = '0;
         w.status = STATUS_DONE;
         case (f)
            FUNC_INSERT: begin
               n_insert++;
               if (fill >= LIST_DEPTH) begin
                  w.status = STATUS_FULL;
                  n_reject++;
               end else begin
                  idx = 0;
                  while (idx < fill && v > slot_val[idx]) idx++;
                  for (i = fill; i > idx; i--) slot_val[i] = slot_val[i-1];
                  slot_val[idx] = v;
                  w.position    = POS_W'(idx);
                  w.comparisons = CNT_W'(idx);
                  w.moves       = CNT_W'(fill - idx);
                  fill++;
                  if (fill == LIST_DEPTH) n_full++;
               end
            end
            FUNC_REMOVE: begin
               n_remove++;
               idx = 0;
               while (idx < fill && slot_val[idx] != v) idx++;
               if (idx >= fill) begin
                  w.status = STATUS_NOT_FOUND;
                  n_miss++;
               end else begin
                  for (i = idx; i + 1 < fill; i++) slot_val[i] = slot_val[i+1];
                  w.position = POS_W'(idx);
                  fill--;
               end
            end
            FUNC_CLEAR: begin
               n_clear++;
               fill = 0;
            end
            default: begin
               n_none++;
            end
         endcase
         w.entry_count = CNT_W'(fill);
         w.is_empty    = (fill == 0);
         w.is_full     = (fill == LIST_DEPTH);
         expected_rsp.push_back(w);
      endfunction

      function void check_response(input rsp_word_type got);
         rsp_word_type exp;
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("[%0t] ERROR: response word with nothing expected", $realtime);
            return;
         end
         exp = expected_rsp.pop_front();
         words_checked++;
         if (got.status      !== exp.status      || got.position !== exp.position ||
             got.comparisons !== exp.comparisons || got.moves    !== exp.moves    ||
             got.entry_count !== exp.entry_count || got.is_empty !== exp.is_empty ||
             got.is_full     !== exp.is_full) begin
            errors++;
            if (errors <= 10) begin
               $display({"[%0t] ERROR word %0d: exp st=%0d pos=%0d cmp=%0d mov=%0d",
                         " cnt=%0d e=%0b f=%0b"},
                        $realtime, words_checked, exp.status, exp.position,
                        exp.comparisons, exp.moves, exp.entry_count, exp.is_empty,
                        exp.is_full);
               $display("            got st=%0d pos=%0d cmp=%0d mov=%0d cnt=%0d e=%0b f=%0b",
                        got.status, got.position, got.comparisons, got.moves,
                        got.entry_count, got.is_empty, got.is_full);
            end
         end
      endfunction
   endclass

   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      req_valid      = 1'b0;
   wire                       req_ready;
   logic [FUNC_W-1:0]         req_func       = FUNC_INSERT;
   logic signed [ITEM_W-1:0]  req_item_value = '0;
   wire                       rsp_valid;
   logic                      rsp_ready      = 1'b0;
   wire  [STATUS_W-1:0]       rsp_status;
   wire  [POS_W-1:0]          rsp_position;
   wire  [CNT_W-1:0]          rsp_comparisons;
   wire  [CNT_W-1:0]          rsp_moves;
   wire  [CNT_W-1:0]          rsp_entry_count;
   wire                       rsp_is_empty;
   wire                       rsp_is_full;

   logic                      quiet     = 1'b0;
   int                        hold_asks = 0;
   int                        cycle_count = 0;
   bit                        idle_on   = 1'b1;
   list_scoreboard            sb;

   sorted_list_insert_remove #(
      .CAPACITY    (LIST_DEPTH),
      .VALUE_WIDTH (ITEM_W)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_comparisons (rsp_comparisons),
      .rsp_moves       (rsp_moves),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** sorted_list_insert_remove: FAILED **");
         $finish;
      end
   end

   task automatic send_word(input logic [FUNC_W-1:0] f, input logic signed [ITEM_W-1:0] v);
      req_func       <= f;
      req_item_value <= v;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(f, v);
   endtask

   task automatic idle_gap();
      int n;
      if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic signed [ITEM_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return ITEM_W'($signed($urandom_range(0, 12)) - 6);
      if (r < 55) begin
         case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            4:       return 32'h8000_0001;
            default: return 32'h7fff_fffe;
         endcase
      end
      return $urandom;
   endfunction

   task automatic gen_word(input int mode, output logic [FUNC_W-1:0] f,
                           output logic signed [ITEM_W-1:0] v);
      int r;
      int ins_pct;
      r       = $urandom_range(0, 99);
      ins_pct = (mode == MODE_FILL) ? 85 : (mode == MODE_DRAIN) ? 20 : 55;
      v       = pick_value();
      if (mode != MODE_FILL && r < 3) begin
         f = FUNC_CLEAR;
      end else if (r < 4) begin
         f = FUNC_NONE;
      end else if (r < ins_pct) begin
         f = FUNC_INSERT;
      end else begin
         f = FUNC_REMOVE;
         if (sb.fill > 0 && $urandom_range(0, 9) < 7)
            v = sb.slot_val[$urandom_range(0, sb.fill - 1)];
      end
   endtask

   // response side: random stall bursts plus long hold-offs on request
   initial begin
      int           stall_left;
      int           hold_left;
      int           mode_left;
      int           hold_seen;
      bit           stall_on;
      rsp_word_type got;
      stall_left = 0;
      hold_left  = 0;
      mode_left  = 0;
      hold_seen  = 0;
      stall_on   = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got = {status_type'(rsp_status), rsp_position, rsp_comparisons, rsp_moves,
                   rsp_entry_count, rsp_is_empty, rsp_is_full};
            sb.check_response(got);
         end
         if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = 150;
         end
         if (mode_left == 0) begin
            stall_on  = ($urandom_range(0, 2) != 0);
            mode_left = $urandom_range(50, 300);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (stall_on && !quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [FUNC_W-1:0]        f;
      logic signed [ITEM_W-1:0] v;
      int                       done;
      int                       k;
      int                       mode;
      int                       wait_left;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, duplicates, extremes, misses, unused code
      send_word(FUNC_CLEAR,  32'h0000_0000);            idle_gap();
      send_word(FUNC_REMOVE, 32'h0000_0000);            idle_gap();
      send_word(FUNC_NONE,   32'h1234_5678);            idle_gap();
      send_word(FUNC_INSERT, 32'h0000_0000);            idle_gap();
      send_word(FUNC_INSERT, 32'h0000_0000);            idle_gap();
      send_word(FUNC_INSERT, 32'h7fff_ffff);            idle_gap();
      send_word(FUNC_INSERT, 32'h8000_0000);            idle_gap();
      send_word(FUNC_INSERT, 32'hffff_ffff);            idle_gap();
      send_word(FUNC_INSERT, 32'h0000_0001);            idle_gap();
      send_word(FUNC_INSERT, 32'h8000_0000);            idle_gap();
      send_word(FUNC_INSERT, 32'h7fff_ffff);            idle_gap();
      send_word(FUNC_REMOVE, 32'h7fff_ffff);            idle_gap();
      send_word(FUNC_REMOVE, 32'h8000_0000);            idle_gap();
      send_word(FUNC_REMOVE, 32'h0000_0005);            idle_gap();
      send_word(FUNC_REMOVE, 32'h0000_0000);            idle_gap();
      send_word(FUNC_NONE,   32'hffff_ffff);            idle_gap();
      send_word(FUNC_INSERT, 32'h5555_5555);            idle_gap();
      send_word(FUNC_INSERT, 32'haaaa_aaaa);            idle_gap();
      send_word(FUNC_CLEAR,  32'hffff_ffff);            idle_gap();
      send_word(FUNC_INSERT, 32'h0000_0007);            idle_gap();
      send_word(FUNC_REMOVE, 32'h0000_0007);            idle_gap();

      done = 0;
      while (done < RANDOM_WORDS) begin
         k = $urandom_range(0, 3);
         mode = (k < 2) ? MODE_FILL : (k == 2) ? MODE_DRAIN : MODE_MIX;
         idle_on = ($urandom_range(0, 3) != 0);
         for (k = 0; k < BLOCK_WORDS && done < RANDOM_WORDS; k++) begin
            if (done == RANDOM_WORDS - 200) quiet <= 1'b1;
            if (done == 300 || done == 900) hold_asks <= hold_asks + 1;
            gen_word(mode, f, v);
            send_word(f, v);
            done++;
            idle_gap();
         end
      end
      req_valid <= 1'b0;

      while (sb.expected_rsp.size() != 0) @(posedge clock);
      wait_left = 10;
      while (wait_left > 0) begin
         @(posedge clock);
         wait_left--;
      end

      $display("Run covered %0d words: %0d inserts (%0d rejected as full),",
               sb.words_checked, sb.n_insert, sb.n_reject);
      $display("  %0d removes (%0d misses), %0d clears, %0d unused codes; filled %0d times.",
               sb.n_remove, sb.n_miss, sb.n_clear, sb.n_none, sb.n_full);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
         $display("** sorted_list_insert_remove: PASSED **");
      end else begin
         $display("%0d errors", sb.errors);
         $display("** sorted_list_insert_remove: FAILED **");
      end
      $finish;
   end

endmodule
